@@ rtl/core/dnc_pkg.sv @@
package dnc_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned LABEL_W = 7;
	localparam int unsigned TOTAL_W = 9;
	localparam int unsigned LEN_W   = 8;

	localparam logic [LABEL_W-1:0] LABEL_MAX = 7'd63;
	localparam logic [LABEL_W-1:0] LABEL_SAT = 7'd127;
	localparam logic [TOTAL_W-1:0] TOTAL_SAT = 9'd511;

	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd253;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [LABEL_W-1:0] label_cnt_t;
	typedef logic [TOTAL_W-1:0] total_cnt_t;
	typedef logic [LEN_W-1:0]   name_len_t;

endpackage

@@ rtl/core/dnc_char_if.sv @@
interface dnc_char_if;
	import dnc_pkg::*;

	logic  valid;
	logic  ready;
	char_t character;
	logic  last_char;
	logic  no_char;

	modport source (output valid, output character, output last_char, output no_char,
		input ready);
	modport sink (input valid, input character, input last_char, input no_char,
		output ready);

endinterface

@@ rtl/core/dnc_result_if.sv @@
interface dnc_result_if;

	logic valid;
	logic ready;
	logic name_valid;

	modport source (output valid, output name_valid, input ready);
	modport sink (input valid, input name_valid, output ready);

endinterface

@@ rtl/core/dns_name_checker_top.sv @@
// A word accepted at a clock edge is registered in the input stage; its result, if it
// carries last_char, is loaded into the result register when that register is free.
// Flow: one word per cycle, but a last_char word waits while a result is held;
// the per-name counters update in the stage after the input register; other words pass.
// Reset (arst_n low, asynchronous): counters and flags clear, both stages empty,
// max_name_length returns to 253.
module dns_name_checker_top (
	input  logic                clk,
	input  logic                arst_n,
	dnc_char_if.sink            chars,
	dnc_result_if.source        result,
	input  logic                cfg_we,
	input  dnc_pkg::name_len_t  cfg_data
);
	import dnc_pkg::*;

	name_len_t  max_len_q;
	label_cnt_t label_count_q;
	total_cnt_t total_count_q;
	logic       prev_hyphen_q;
	logic       error_seen_q;

	logic  valid_s1;
	char_t char_s1;
	logic  last_s1;
	logic  none_s1;

	logic  res_valid_q;
	logic  res_name_valid_q;

	logic       out_free;
	logic       adv_s1;
	logic       is_dot;
	logic       is_hyphen;
	logic       is_ldh;
	label_cnt_t label_inc;
	label_cnt_t label_nx;
	total_cnt_t total_nx;
	logic       hyphen_nx;
	logic       error_nx;
	logic       name_ok;

	assign out_free    = !res_valid_q || result.ready;
	assign adv_s1      = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || adv_s1;

	assign result.valid      = res_valid_q;
	assign result.name_valid = res_name_valid_q;

	always_comb begin
		is_dot    = (char_s1 == CH_DOT);
		is_hyphen = (char_s1 == CH_HYPHEN);
		is_ldh    = ((char_s1 >= CH_LOW_A) && (char_s1 <= CH_LOW_Z)) ||
			((char_s1 >= CH_DIG_0) && (char_s1 <= CH_DIG_9)) || is_hyphen;
		label_inc = (label_count_q < LABEL_SAT) ? label_count_q + 7'd1 : label_count_q;

		label_nx  = label_count_q;
		total_nx  = total_count_q;
		hyphen_nx = prev_hyphen_q;
		error_nx  = error_seen_q;
		if (!none_s1) begin
			total_nx = (total_count_q < TOTAL_SAT) ? total_count_q + 9'd1 : total_count_q;
			if (is_dot) begin
				// empty label or label ending in a hyphen
				error_nx  = error_seen_q || (label_count_q == '0) || prev_hyphen_q;
				label_nx  = '0;
				hyphen_nx = 1'b0;
			end else begin
				error_nx  = error_seen_q || !is_ldh ||
					((label_count_q == '0) && is_hyphen) || (label_inc > LABEL_MAX);
				label_nx  = label_inc;
				hyphen_nx = is_hyphen;
			end
		end

		if (total_nx == '0) begin
			name_ok = !error_nx;
		end else begin
			name_ok = !error_nx && (label_nx != '0) && !hyphen_nx &&
				(total_nx <= {1'b0, max_len_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.character;
			last_s1 <= chars.last_char;
			none_s1 <= chars.no_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= '0;
			total_count_q <= '0;
			prev_hyphen_q <= 1'b0;
			error_seen_q  <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				// clear for the next name
				label_count_q <= '0;
				total_count_q <= '0;
				prev_hyphen_q <= 1'b0;
				error_seen_q  <= 1'b0;
			end else begin
				label_count_q <= label_nx;
				total_count_q <= total_nx;
				prev_hyphen_q <= hyphen_nx;
				error_seen_q  <= error_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && last_s1) begin
			res_name_valid_q <= name_ok;
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (label_count_q == '0) && (total_count_q == '0) &&
			!error_seen_q && !prev_hyphen_q)
		else $error("running state not cleared after end of name");

	a_label_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		label_count_q <= {2'b00, total_count_q[TOTAL_W-1:2]} ||
			label_count_q <= total_count_q[LABEL_W-1:0] || total_count_q > 9'd127)
		else $error("label count exceeds total count");

	a_long_label_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(label_count_q > LABEL_MAX) |-> error_seen_q)
		else $error("overlong label without error flag");

	a_result_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid_q)) |-> $past(adv_s1 && last_s1))
		else $error("result raised without end of name");
`endif

endmodule

@@ bench/dnc_verdict_checker.sv @@
`timescale 1ns / 1ps
module dnc_verdict_checker (
	input  logic                clk,
	input  logic                arst_n,
	dnc_char_if                 chars,
	dnc_result_if               result,
	input  logic                cfg_we,
	input  dnc_pkg::name_len_t  cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import dnc_pkg::*;

	name_len_t  len_limit;
	label_cnt_t label_len;
	total_cnt_t name_len;
	logic       hyphen_before;
	logic       broken;
	bit         want_valid;
	bit         verdicts_q[$];

	task automatic clear_name();
		label_len     = '0;
		name_len      = '0;
		hyphen_before = 1'b0;
		broken        = 1'b0;
	endtask

	task automatic absorb_char(input char_t c);
		logic ldh;
		ldh = (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
			c == CH_HYPHEN;
		if (name_len != TOTAL_SAT)
			name_len++;
		if (c == CH_DOT) begin
			// empty label or label ending in a hyphen
			if (label_len == '0 || hyphen_before)
				broken = 1'b1;
			label_len     = '0;
			hyphen_before = 1'b0;
		end else begin
			if (!ldh || (label_len == '0 && c == CH_HYPHEN))
				broken = 1'b1;
			if (label_len != LABEL_SAT)
				label_len++;
			if (label_len > LABEL_MAX)
				broken = 1'b1;
			hyphen_before = (c == CH_HYPHEN);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit = MAX_LEN_RESET;
			clear_name();
			verdicts_q.delete();
			pending = 0;
		end else begin
			// results leave only after their word has been registered, so pop before push
			if (result.valid && result.ready) begin
				if (verdicts_q.size() == 0) begin
					$display("%0t: name_valid expected none, got %0b", $time, result.name_valid);
					fail_count++;
				end else begin
					want_valid = verdicts_q.pop_front();
					if (result.name_valid !== want_valid) begin
						$display("%0t: name_valid expected %0b, got %0b", $time, want_valid,
							result.name_valid);
						fail_count++;
					end
				end
			end
			if (chars.valid && chars.ready) begin
				if (!chars.no_char)
					absorb_char(chars.character);
				if (chars.last_char) begin
					if (name_len == '0)
						verdicts_q.push_back(!broken);
					else
						verdicts_q.push_back(!broken && label_len != '0 && !hyphen_before &&
							name_len <= {1'b0, len_limit});
					clear_name();
				end
			end
			if (cfg_we)
				len_limit = cfg_data;
			pending = verdicts_q.size();
		end
	end

endmodule

@@ bench/tb_dns_name_checker_top.sv @@
`timescale 1ns / 1ps
module tb_dns_name_checker_top;
	import dnc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int RANDOM_WORDS   = 240;
	localparam int PHASES         = 8;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	name_len_t cfg_data;
	int        fail_count;
	int        pending;
	int        words_sent;
	int        stall_cycles;
	int        src_calm;
	int        sink_calm;
	char_t     name_buf[$];

	dnc_char_if   chars_if();
	dnc_result_if result_if();

	dns_name_checker_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	dnc_verdict_checker u_verdicts (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars_if),
		.result     (result_if),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random gap, with occasional calm stretches of back-to-back words
	function automatic int pick_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 14);
	endfunction

	function automatic char_t ldh_pick(input bit with_hyphen);
		int r;
		r = $urandom_range(0, with_hyphen ? 36 : 35);
		if (r < 26)
			return CH_LOW_A + char_t'(r);
		if (r < 36)
			return CH_DIG_0 + char_t'(r - 26);
		return CH_HYPHEN;
	endfunction

	task automatic send_word(input char_t c, input logic last, input logic none);
		int gap;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			chars_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.valid     = 1'b1;
		chars_if.character = c;
		chars_if.last_char = last;
		chars_if.no_char   = none;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// send name_buf; optionally end on a character-less word, sprinkle empty words
	task automatic send_name(input bit tail_blank, input int blank_pct);
		int n;
		int i;
		n = name_buf.size();
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < blank_pct)
				send_word(char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
			send_word(name_buf[i], (i == n - 1) && !tail_blank, 1'b0);
		end
		if (n == 0 || tail_blank)
			send_word(char_t'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic send_text(input string s, input bit tail_blank, input int blank_pct);
		int i;
		name_buf.delete();
		for (i = 0; i < s.len(); i++)
			name_buf.push_back(s[i]);
		send_name(tail_blank, blank_pct);
	endtask

	task automatic add_label(input int len);
		int i;
		for (i = 0; i < len; i++)
			name_buf.push_back(ldh_pick(i != 0 && i != len - 1));
	endtask

	// append a well-formed name of exactly n characters
	task automatic add_sized(input int n);
		int left;
		int lab;
		left = n;
		while (left > 0) begin
			lab = (left < 63) ? left : $urandom_range(1, 63);
			if (left - lab == 1)
				lab = lab - 1;
			add_label(lab);
			left -= lab;
			if (left > 0) begin
				name_buf.push_back(CH_DOT);
				left--;
			end
		end
	endtask

	task automatic mutate_name();
		int pos;
		if (name_buf.size() == 0) begin
			name_buf.push_back(CH_DOT);
		end else begin
			pos = $urandom_range(0, name_buf.size() - 1);
			case ($urandom_range(0, 6))
				0: name_buf[pos] = char_t'($urandom_range(0, 255));
				1: name_buf.push_front(CH_DOT);
				2: name_buf.push_back(CH_DOT);
				3: name_buf.insert(pos, CH_DOT);
				4: name_buf.push_front(CH_HYPHEN);
				5: name_buf.push_back(CH_HYPHEN);
				default: name_buf[pos] = CH_LOW_A - 8'h20 + char_t'($urandom_range(0, 25));
			endcase
		end
	endtask

	task automatic build_random(input int lim);
		int kind;
		int n;
		int j;
		name_buf.delete();
		kind = $urandom_range(0, 19);
		if (kind >= 1 && kind <= 2) begin
			// noise, biased towards separators
			n = $urandom_range(1, 12);
			for (j = 0; j < n; j++) begin
				case ($urandom_range(0, 3))
					0: name_buf.push_back(CH_DOT);
					1: name_buf.push_back(CH_HYPHEN);
					default: name_buf.push_back(char_t'($urandom_range(0, 255)));
				endcase
			end
		end else if (kind > 2) begin
			if (kind <= 4) begin
				n = lim + $urandom_range(0, 4) - 2;
				add_sized(n < 0 ? 0 : n);
			end else begin
				n = $urandom_range(1, 4);
				for (j = 0; j < n; j++) begin
					if (j != 0)
						name_buf.push_back(CH_DOT);
					add_label(($urandom_range(0, 15) == 0) ? $urandom_range(60, 64) :
						$urandom_range(1, 8));
				end
			end
			if (kind >= 15)
				mutate_name();
		end
	endtask

	task automatic set_max_len(input name_len_t v);
		chars_if.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// let the pipeline empty of result-less words too
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	initial begin
		int gap;
		result_if.ready = 1'b0;
		forever begin
			gap = pick_gap(sink_calm);
			if (gap > 0) begin
				result_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_if.ready = 1'b1;
			@(posedge clk);
			while (!result_if.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		char_t     fence_bytes[8];
		name_len_t lim;
		int        p;
		int        k;
		int        target;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_data           = MAX_LEN_RESET;
		chars_if.valid     = 1'b0;
		chars_if.character = '0;
		chars_if.last_char = 1'b0;
		chars_if.no_char   = 1'b0;
		words_sent         = 0;
		src_calm           = 0;
		sink_calm          = 0;
		fence_bytes = '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset maximum
		send_text("", 1'b0, 0);
		send_text("a", 1'b0, 0);
		send_text("a.b", 1'b0, 0);
		send_text("-a", 1'b0, 0);
		send_text("a-", 1'b0, 0);
		send_text("a-b", 1'b0, 0);
		send_text(".a", 1'b0, 0);
		send_text("a.", 1'b0, 0);
		send_text("a..b", 1'b0, 0);
		send_text("0z9.b-c", 1'b0, 0);
		send_text("Abc", 1'b0, 0);
		send_text("ab", 1'b0, 100);
		send_text("ab", 1'b1, 0);
		send_text("a-", 1'b1, 0);
		for (k = 0; k < 8; k++) begin
			name_buf.delete();
			name_buf.push_back(CH_LOW_A);
			name_buf.push_back(fence_bytes[k]);
			send_name(1'b0, 0);
		end
		name_buf.delete(); add_label(63); send_name(1'b0, 0);
		name_buf.delete(); add_label(64); send_name(1'b0, 0);

		set_max_len(8'd5);
		send_text("ab.cd", 1'b0, 0);
		send_text("ab.cde", 1'b0, 0);
		set_max_len(8'd1);
		send_text("a", 1'b0, 0);
		send_text("ab", 1'b0, 0);
		send_text("a", 1'b1, 0);
		set_max_len(8'd0);
		send_text("a", 1'b0, 0);
		send_text("", 1'b0, 0);

		// random phases, each under its own maximum
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: lim = 8'd255;
				1: lim = 8'd0;
				2: lim = 8'd1;
				3: lim = name_len_t'($urandom_range(2, 40));
				default: lim = name_len_t'($urandom_range(1, 255));
			endcase
			set_max_len(lim);
			target = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < target) begin
				build_random(lim);
				send_name($urandom_range(0, 4) == 0, ($urandom_range(0, 1) == 0) ? 0 : 10);
			end
		end

		chars_if.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
